/* rtl/assert_macros.svh */
// assertion macros used by the rtl top level sorted_priority_queue.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked the cycle after its trigger
`define SPQ_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

/* rtl/spq_pkg.sv */
// shared constants, codes and types of the sorted priority queue
package spq_pkg;

  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 16;
  localparam int PRIO_WIDTH  = 16;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int IDX_W       = $clog2(CAPACITY);

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
  localparam logic [OP_W-1:0] OP_POP_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd2;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]       value;
    logic signed [PRIO_WIDTH-1:0] prio;
  } entry_t;

  // what the whole row does this cycle
  typedef struct packed {
    logic push;
    logic pop_head;
  } cell_ctrl_t;

  // where a cell stands relative to the current fill level
  typedef struct packed {
    logic occupied;
    logic last;
    logic free;
  } cell_pos_t;

endpackage

/* rtl/spq_cell.sv */
// one slot of the sorted row: holds an entry and shifts it left or right
module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::cell_pos_t  pos_i,
  input  spq_pkg::entry_t     item_i,
  input  spq_pkg::entry_t     left_i,
  input  spq_pkg::entry_t     right_i,
  input  logic                le_left_i,
  input  logic                go_left_i,
  output logic                le_o,
  output logic                go_o,
  output spq_pkg::entry_t     entry_q_o,
  output spq_pkg::entry_t     entry_d_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;
  logic   eq;
  logic   mv;

  assign le_o = pos_i.occupied && ($signed(entry_q.prio) <= $signed(item_i.prio));
  assign eq   = (entry_q.prio == item_i.prio);
  // the last entry stays put on an equal priority when it is the only one not above
  assign go_o = le_o && !(pos_i.last && eq && !le_left_i);
  assign mv   = go_o || pos_i.free;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      if (go_left_i) begin
        entry_d = left_i;
      end else if (mv) begin
        entry_d = item_i;
      end
    end else if (ctrl_i.pop_head) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_q_o = entry_q;
  assign entry_d_o = entry_d;

endmodule

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue of spq_pkg::CAPACITY entries held in a row of shifting cells.
// One operation is accepted per cycle unless a result is stalled: all cells
// compare their priority with a pushed one in parallel, so a push, pop or clear
// finishes in the cycle it is accepted. The result word appears on the master side
// the cycle after acceptance and sits in an output register, so input is still
// taken while a result waits as long as the master side is ready in that cycle.
// A push lands ahead of entries of equal priority, except that a push equal to the
// back entry, with no other entry at or below it, lands behind that entry.
`include "assert_macros.svh"

module sorted_priority_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op [2:0], item_value [18:3], item_priority [34:19], zero [39:35]
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // popped_value [15:0], status [17:16], entry_count [22:18], is_empty [23],
  // head_value [39:24], head_priority [55:40], tail_priority [71:56]
  output logic [71:0] m_axis_tdata
);
  import spq_pkg::*;

  logic [OP_W-1:0] op;
  entry_t          item;
  logic            acc;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] last_idx, last_idx_d;

  entry_t    cell_q   [CAPACITY];
  entry_t    cell_d   [CAPACITY];
  entry_t    left_in  [CAPACITY];
  entry_t    right_in [CAPACITY];
  cell_pos_t pos      [CAPACITY];
  logic [CAPACITY-1:0] le, go, le_left, go_left;

  cell_ctrl_t ctrl;
  logic       full, empty;
  logic       push_ok, popf_ok, popb_ok;

  logic [VALUE_WIDTH-1:0] popped;
  logic [STATUS_W-1:0]    status;

  logic        out_valid_q, out_valid_d;
  logic [71:0] out_data_q, out_data_d;

  assign op         = s_axis_tdata[2:0];
  assign item.value = s_axis_tdata[18:3];
  assign item.prio  = s_axis_tdata[34:19];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign last_idx = count_q - CNT_W'(1);

  assign push_ok = (op == OP_PUSH) && !full;
  assign popf_ok = (op == OP_POP_FRONT) && !empty;
  assign popb_ok = (op == OP_POP_BACK) && !empty;

  assign ctrl.push     = acc && push_ok;
  assign ctrl.pop_head = acc && popf_ok;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      pos[i].occupied = (CNT_W'(i) < count_q);
      pos[i].last     = !empty && (CNT_W'(i) == last_idx);
      pos[i].free     = (CNT_W'(i) == count_q);
      if (i == 0) begin
        left_in[i] = '0;
        le_left[i] = 1'b0;
        go_left[i] = 1'b0;
      end else begin
        left_in[i] = cell_q[i-1];
        le_left[i] = le[i-1];
        go_left[i] = go[i-1];
      end
      if (i == CAPACITY - 1) begin
        right_in[i] = cell_q[i];
      end else begin
        right_in[i] = cell_q[i+1];
      end
    end
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    spq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .pos_i     (pos[gi]),
      .item_i    (item),
      .left_i    (left_in[gi]),
      .right_i   (right_in[gi]),
      .le_left_i (le_left[gi]),
      .go_left_i (go_left[gi]),
      .le_o      (le[gi]),
      .go_o      (go[gi]),
      .entry_q_o (cell_q[gi]),
      .entry_d_o (cell_d[gi])
    );
  end

  always_comb begin
    count_d = count_q;
    popped  = '0;
    status  = ST_OK;
    unique case (op)
      OP_PUSH: begin
        if (full) begin
          status = ST_PUSH_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status = ST_POP_EMPTY;
        end else begin
          popped  = cell_q[0].value;
          count_d = last_idx;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status = ST_POP_EMPTY;
        end else begin
          popped  = cell_q[last_idx[IDX_W-1:0]].value;
          count_d = last_idx;
        end
      end
      OP_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  assign last_idx_d = count_d - CNT_W'(1);

  always_comb begin
    out_data_d          = '0;
    out_data_d[15:0]    = popped;
    out_data_d[17:16]   = status;
    out_data_d[22:18]   = count_d;
    out_data_d[23]      = (count_d == '0);
    if (count_d != '0) begin
      out_data_d[39:24] = cell_d[0].value;
      out_data_d[55:40] = cell_d[0].prio;
      out_data_d[71:56] = cell_d[last_idx_d[IDX_W-1:0]].prio;
    end
  end

  assign out_valid_d = acc || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        count_q <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `SPQ_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "fill count above capacity")
  `SPQ_ASSERT_NEXT(a_result_follows, acc, m_axis_tvalid, "accepted word gave no result")
  `SPQ_ASSERT_NEXT(a_push_grows, acc && push_ok, count_q == $past(count_q) + CNT_W'(1),
    "push did not grow the queue")
  `SPQ_ASSERT_NEXT(a_full_holds, acc && (op == OP_PUSH) && full,
    count_q == $past(count_q), "push on full queue changed the count")

endmodule

/* sim/tb_sorted_priority_queue.sv */
// testbench for the sorted priority queue: directed corners and random traffic checked against a shadow list
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int OP_MAX        = 2 ** OP_W - 1;
  localparam int HANG_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int REPORT_LIMIT  = 10;

  // op [2:0], item_value [18:3], item_priority [34:19], zero [39:35]
  typedef struct packed {
    logic [4:0]                   pad;
    logic signed [PRIO_WIDTH-1:0] prio;
    logic [VALUE_WIDTH-1:0]       value;
    logic [OP_W-1:0]              op;
  } queue_cmd_t;

  // popped_value [15:0], status [17:16], entry_count [22:18], is_empty [23],
  // head_value [39:24], head_priority [55:40], tail_priority [71:56]
  typedef struct packed {
    logic signed [PRIO_WIDTH-1:0] tail_prio;
    logic signed [PRIO_WIDTH-1:0] head_prio;
    logic [VALUE_WIDTH-1:0]       head_value;
    logic                         is_empty;
    logic [CNT_W-1:0]             entry_count;
    logic [STATUS_W-1:0]          status;
    logic [VALUE_WIDTH-1:0]       popped_value;
  } queue_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  sorted_priority_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  queue_cmd_t    pending_cmds[$];
  queue_report_t expected_reports[$];

  // shadow copy of the sorted list
  logic [VALUE_WIDTH-1:0]       shadow_value[CAPACITY];
  logic signed [PRIO_WIDTH-1:0] shadow_prio[CAPACITY];
  int                           shadow_fill = 0;

  int          mismatch_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_hold = 0;
  logic [15:0] stall_pattern = '1;
  logic [15:0] next_pattern;
  int          idle_cycles = 0;
  logic        hung = 1'b0;

  task automatic add_cmd(input logic [OP_W-1:0] op, input logic [VALUE_WIDTH-1:0] value,
                         input logic signed [PRIO_WIDTH-1:0] prio);
    queue_cmd_t cmd;
    cmd = '0;
    cmd.op = op;
    cmd.value = value;
    cmd.prio = prio;
    pending_cmds.push_back(cmd);
  endtask

  // applies one accepted word to the shadow list and queues the report it should produce
  task automatic apply_cmd(input queue_cmd_t cmd);
    queue_report_t rep;
    int            pos;
    int            i;
    logic          found;
    rep = '0;
    rep.status = ST_OK;
    case (cmd.op)
      OP_PUSH: begin
        if (shadow_fill >= CAPACITY) begin
          rep.status = ST_PUSH_FULL;
        end else begin
          pos = shadow_fill;
          found = 1'b0;
          for (i = 0; i < shadow_fill; i++) begin
            if (!found && shadow_prio[i] <= cmd.prio) begin
              pos = i;
              found = 1'b1;
            end
          end
          // a tie with the back entry lands behind it
          if (shadow_fill > 0 && pos == shadow_fill - 1 && shadow_prio[pos] == cmd.prio)
            pos = shadow_fill;
          for (i = shadow_fill; i > pos; i--) begin
            shadow_value[i] = shadow_value[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_value[pos] = cmd.value;
          shadow_prio[pos] = cmd.prio;
          shadow_fill++;
        end
      end
      OP_POP_FRONT: begin
        if (shadow_fill == 0) begin
          rep.status = ST_POP_EMPTY;
        end else begin
          rep.popped_value = shadow_value[0];
          for (i = 1; i < shadow_fill; i++) begin
            shadow_value[i-1] = shadow_value[i];
            shadow_prio[i-1] = shadow_prio[i];
          end
          shadow_fill--;
        end
      end
      OP_POP_BACK: begin
        if (shadow_fill == 0) begin
          rep.status = ST_POP_EMPTY;
        end else begin
          rep.popped_value = shadow_value[shadow_fill-1];
          shadow_fill--;
        end
      end
      OP_CLEAR: begin
        shadow_fill = 0;
      end
      default: begin
      end
    endcase
    rep.entry_count = shadow_fill[CNT_W-1:0];
    rep.is_empty = (shadow_fill == 0);
    if (shadow_fill != 0) begin
      rep.head_value = shadow_value[0];
      rep.head_prio = shadow_prio[0];
      rep.tail_prio = shadow_prio[shadow_fill-1];
    end
    expected_reports.push_back(rep);
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  task automatic check_report(input queue_report_t got);
    queue_report_t want;
    if (expected_reports.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("result word %h with nothing expected", got);
    end else begin
      want = expected_reports[0];
      expected_reports.delete(0);
      compare_field("popped_value", want.popped_value, got.popped_value);
      compare_field("status", 16'(want.status), 16'(got.status));
      compare_field("entry_count", 16'(want.entry_count), 16'(got.entry_count));
      compare_field("is_empty", 16'(want.is_empty), 16'(got.is_empty));
      compare_field("head_value", want.head_value, got.head_value);
      compare_field("head_priority", want.head_prio, got.head_prio);
      compare_field("tail_priority", want.tail_prio, got.tail_prio);
    end
  endtask

  // driver: bursts of words separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        s_axis_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_cmds.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_cmds[0];
        pending_cmds.delete(0);
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: checks results, tracks accepted words and stalls the master side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_pattern <= '1;
      stall_hold <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        check_report(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        apply_cmd(s_axis_tdata);
      next_pattern = stall_pattern;
      if (stall_hold == 0) begin
        stall_hold <= $urandom_range(16, 120);
        case ($urandom_range(0, 2))
          0: next_pattern = '1;
          1: next_pattern = 16'($urandom);
          default: next_pattern = 16'($urandom) & 16'($urandom) | 16'h0001;
        endcase
      end else begin
        stall_hold <= stall_hold - 1;
      end
      m_axis_tready <= next_pattern[0];
      stall_pattern <= {next_pattern[0], next_pattern[15:1]};
    end
  end

  // watchdog on cycles with work outstanding and no word accepted
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_cmds.size() == 0 && !s_axis_tvalid && expected_reports.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      hung <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                           n;
    int                           phase_len;
    int                           phase_kind;
    int                           prio_mode;
    int                           pick;
    logic [OP_W-1:0]              op;
    logic signed [PRIO_WIDTH-1:0] prio;

    // empty queue corners
    add_cmd(OP_POP_FRONT, 16'hFFFF, 16'sh7FFF);
    add_cmd(OP_POP_BACK, 16'h0000, 16'sh8000);
    add_cmd(OP_QUERY, 16'h1234, 16'sh0000);
    add_cmd(OP_CLEAR, 16'hFFFF, 16'shFFFF);
    // single entry, then an equal push goes behind it
    add_cmd(OP_PUSH, 16'h0F0F, 16'sh0005);
    add_cmd(OP_PUSH, 16'hF0F0, 16'sh0005);
    add_cmd(OP_POP_FRONT, 16'h0000, 16'sh0000);
    add_cmd(OP_POP_FRONT, 16'h0000, 16'sh0000);
    // priority extremes, tie at the back and tie at the front
    add_cmd(OP_PUSH, 16'hFFFF, 16'sh7FFF);
    add_cmd(OP_PUSH, 16'h0000, 16'sh8000);
    add_cmd(OP_PUSH, 16'h1234, 16'sh8000);
    add_cmd(OP_PUSH, 16'h5555, 16'sh7FFF);
    add_cmd(OP_PUSH, 16'hAAAA, 16'sh0000);
    add_cmd(OP_PUSH, 16'h00FF, 16'shFFFF);
    add_cmd(3'(OP_QUERY + 1), 16'hFFFF, 16'sh7FFF);
    add_cmd(3'(OP_MAX), 16'h8001, 16'sh8001);
    add_cmd(OP_POP_FRONT, 16'hFFFF, 16'sh7FFF);
    add_cmd(OP_POP_BACK, 16'hFFFF, 16'sh7FFF);
    add_cmd(OP_QUERY, 16'h0000, 16'sh0000);
    add_cmd(OP_CLEAR, 16'h0000, 16'sh0000);
    add_cmd(OP_POP_BACK, 16'h0000, 16'sh0000);

    // random phases that fill, drain or mix so the queue swings between empty and full
    n = 0;
    while (n < RANDOM_ITEMS) begin
      phase_len = $urandom_range(10, 60);
      phase_kind = $urandom_range(0, 2);
      prio_mode = $urandom_range(0, 3);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        case (phase_kind)
          0: op = (pick < 75) ? OP_PUSH : (pick < 85) ? OP_POP_FRONT :
                  (pick < 92) ? OP_POP_BACK : (pick < 96) ? OP_QUERY :
                  (pick < 99) ? 3'($urandom_range(OP_QUERY + 1, OP_MAX)) : OP_CLEAR;
          1: op = (pick < 15) ? OP_PUSH : (pick < 55) ? OP_POP_FRONT :
                  (pick < 93) ? OP_POP_BACK : (pick < 96) ? OP_QUERY :
                  (pick < 98) ? 3'($urandom_range(OP_QUERY + 1, OP_MAX)) : OP_CLEAR;
          default: op = (pick < 48) ? OP_PUSH : (pick < 70) ? OP_POP_FRONT :
                        (pick < 90) ? OP_POP_BACK : (pick < 95) ? OP_QUERY :
                        (pick < 98) ? 3'($urandom_range(OP_QUERY + 1, OP_MAX)) : OP_CLEAR;
        endcase
        case (prio_mode)
          // narrow band forces plenty of ties
          0: prio = 16'($urandom_range(0, 6)) - 16'sd3;
          1: begin
            case ($urandom_range(0, 3))
              0: prio = 16'sh7FFF;
              1: prio = 16'sh8000;
              2: prio = 16'sh0000;
              default: prio = 16'shFFFF;
            endcase
          end
          default: prio = 16'($urandom);
        endcase
        add_cmd(op, 16'($urandom), prio);
        n++;
      end
    end

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample away from the rising edge so the driver and monitor updates have settled
    while (!hung && (pending_cmds.size() != 0 || s_axis_tvalid ||
                     expected_reports.size() != 0))
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!hung && mismatch_count == 0 && expected_reports.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
